// File: sv/cst_pkg.sv
// Package for the C subset token scanner: token and group types, token kind
// codes, scanner modes, keyword table and saturating counter helpers.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cst_pkg;

    localparam int KW_BUF_LEN  = 8;
    localparam int LINE_W      = 20;
    localparam int COL_W       = 16;
    localparam int OFF_W       = 32;
    localparam int LEN_W       = 16;
    localparam int KIND_W      = 6;
    localparam int MAX_TOKENS  = 3;
    localparam int NUM_KW      = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int TDATA_W     = 96;

    // Token kind codes.
    localparam logic [KIND_W-1:0] K_EOF       = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT     = 6'd1;
    localparam logic [KIND_W-1:0] K_INT_LIT   = 6'd2;
    localparam logic [KIND_W-1:0] K_FLOAT_LIT = 6'd3;
    localparam logic [KIND_W-1:0] K_LONG_LIT  = 6'd4;
    localparam logic [KIND_W-1:0] K_STR_LIT   = 6'd5;
    localparam logic [KIND_W-1:0] K_KW0       = 6'd6;
    localparam logic [KIND_W-1:0] K_LPAREN    = 6'd17;
    localparam logic [KIND_W-1:0] K_RPAREN    = 6'd18;
    localparam logic [KIND_W-1:0] K_LBRACE    = 6'd19;
    localparam logic [KIND_W-1:0] K_RBRACE    = 6'd20;
    localparam logic [KIND_W-1:0] K_LBRACKET  = 6'd21;
    localparam logic [KIND_W-1:0] K_RBRACKET  = 6'd22;
    localparam logic [KIND_W-1:0] K_SEMI      = 6'd23;
    localparam logic [KIND_W-1:0] K_COMMA     = 6'd24;
    localparam logic [KIND_W-1:0] K_PLUS      = 6'd25;
    localparam logic [KIND_W-1:0] K_MINUS     = 6'd26;
    localparam logic [KIND_W-1:0] K_STAR      = 6'd27;
    localparam logic [KIND_W-1:0] K_SLASH     = 6'd28;
    localparam logic [KIND_W-1:0] K_PERCENT   = 6'd29;
    localparam logic [KIND_W-1:0] K_INC       = 6'd30;
    localparam logic [KIND_W-1:0] K_DEC       = 6'd31;
    localparam logic [KIND_W-1:0] K_PLUSEQ    = 6'd32;
    localparam logic [KIND_W-1:0] K_MINUSEQ   = 6'd33;
    localparam logic [KIND_W-1:0] K_ASSIGN    = 6'd34;
    localparam logic [KIND_W-1:0] K_EQ        = 6'd35;
    localparam logic [KIND_W-1:0] K_NE        = 6'd36;
    localparam logic [KIND_W-1:0] K_NOT       = 6'd37;
    localparam logic [KIND_W-1:0] K_LT        = 6'd38;
    localparam logic [KIND_W-1:0] K_LE        = 6'd39;
    localparam logic [KIND_W-1:0] K_GT        = 6'd40;
    localparam logic [KIND_W-1:0] K_GE        = 6'd41;
    localparam logic [KIND_W-1:0] K_AND       = 6'd42;
    localparam logic [KIND_W-1:0] K_OR        = 6'd43;
    localparam logic [KIND_W-1:0] K_UNKNOWN   = 6'd44;

    // Scanner modes.
    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUM, M_NUM_DOT, M_STR, M_LINE, M_BLOCK, M_BLOCK_STAR,
        M_SLASH, M_PLUS, M_MINUS, M_EQ, M_BANG, M_LT, M_GT, M_AMP, M_BAR
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
    } token_t;

    // All tokens caused by one input item; count is 1 to 3.
    typedef struct packed {
        token_t [MAX_TOKENS-1:0] tok;
        logic [1:0]              count;
    } group_t;

    typedef logic [KW_BUF_LEN-1:0][7:0] prefix_t;

    // Keyword spellings, zero padded.
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_BUF_LEN] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"l", "o", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "n", "s", "i", "g", "n", "e", "d"},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", "f", 8'h00, 8'h00},
        '{"i", "n", "c", "l", "u", "d", "e", 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd5, 4'd4, 4'd8, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd6, 4'd7
    };

    // Identifier or keyword kind for a finished identifier.
    function automatic logic [KIND_W-1:0] ident_kind(prefix_t pf, logic [LEN_W-1:0] len);
        logic [KIND_W-1:0] kind;
        logic              hit;
        kind = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--) begin
            hit = (len == LEN_W'(KW_LEN[i]));
            for (int j = 0; j < KW_BUF_LEN; j++) begin
                if ((LEN_W'(j) < len) && (pf[j] != KW_TEXT[i][j])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = K_KW0 + KIND_W'(i);
            end
        end
        return kind;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic [LINE_W-1:0] sat_inc_line(logic [LINE_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [COL_W-1:0] sat_inc_col(logic [COL_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFF_W-1:0] sat_inc_off(logic [OFF_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc_len(logic [LEN_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [COL_W-1:0] sat_add_col(logic [COL_W-1:0] a,
                                                     logic [LEN_W-1:0] b);
        logic [COL_W:0] s;
        s = {1'b0, a} + (COL_W + 1)'(b);
        return s[COL_W] ? {COL_W{1'b1}} : s[COL_W-1:0];
    endfunction

    function automatic logic [OFF_W-1:0] sat_add_off(logic [OFF_W-1:0] a,
                                                     logic [LEN_W-1:0] b);
        logic [OFF_W:0] s;
        s = {1'b0, a} + (OFF_W + 1)'(b);
        return s[OFF_W] ? {OFF_W{1'b1}} : s[OFF_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/cst_front.sv
// Scanner front end: accepts source bytes, runs the lexer state machine and
// produces the group of tokens each byte completes. Depends on cst_pkg.
`default_nettype none

module cst_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_fire,
    input  wire logic            in_op,
    input  wire logic [7:0]      in_ch,
    output cst_pkg::group_t      grp,
    output logic                 grp_push
);

    cst_pkg::mode_t              mode_reg, mode_next;
    logic [cst_pkg::LINE_W-1:0]  line_reg, line_next;
    logic [cst_pkg::COL_W-1:0]   col_reg, col_next;
    logic [cst_pkg::OFF_W-1:0]   off_reg, off_next;
    logic [cst_pkg::LINE_W-1:0]  sline_reg, sline_next;
    logic [cst_pkg::COL_W-1:0]   scol_reg, scol_next;
    logic [cst_pkg::OFF_W-1:0]   soff_reg, soff_next;
    logic [cst_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                        frac_reg, frac_next;
    logic                        fin_reg, fin_next;
    cst_pkg::prefix_t            prefix_reg;
    logic                        pf_we;
    logic [2:0]                  pf_idx;
    logic [1:0]                  cnt;
    logic                        again;
    logic [cst_pkg::KIND_W-1:0]  idk;
    logic [7:0]                  c;

    assign c   = in_ch;
    assign idk = cst_pkg::ident_kind(prefix_reg, len_reg);

    // Control and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= cst_pkg::M_IDLE;
            line_reg  <= cst_pkg::LINE_W'(1);
            col_reg   <= cst_pkg::COL_W'(1);
            off_reg   <= '0;
            sline_reg <= '0;
            scol_reg  <= '0;
            soff_reg  <= '0;
            len_reg   <= '0;
            frac_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            soff_reg  <= soff_next;
            len_reg   <= len_next;
            frac_reg  <= frac_next;
            fin_reg   <= fin_next;
        end
    end

    // Identifier prefix store; only entries below the length are ever read.
    always_ff @(posedge aclk) begin
        if (pf_we) begin
            prefix_reg[pf_idx] <= c;
        end
    end

    // Next state and the tokens completed by this item.
    always_comb begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        soff_next  = soff_reg;
        len_next   = len_reg;
        frac_next  = frac_reg;
        fin_next   = fin_reg;
        pf_we      = 1'b0;
        pf_idx     = '0;
        grp        = '0;
        cnt        = '0;
        again      = 1'b0;

        if (in_fire && !fin_reg) begin
            if (in_op) begin
                // End of input: flush the pending token, then end-of-file.
                unique case (mode_reg)
                    cst_pkg::M_IDENT: begin
                        grp.tok[cnt] = '{idk, sline_reg, scol_reg, soff_reg, len_reg};
                        cnt = cnt + 2'd1;
                    end
                    cst_pkg::M_NUM: begin
                        grp.tok[cnt] = '{frac_reg ? cst_pkg::K_FLOAT_LIT : cst_pkg::K_INT_LIT,
                                         sline_reg, scol_reg, soff_reg, len_reg};
                        cnt = cnt + 2'd1;
                    end
                    cst_pkg::M_NUM_DOT: begin
                        grp.tok[cnt] = '{cst_pkg::K_INT_LIT, sline_reg, scol_reg, soff_reg,
                                         len_reg};
                        cnt = cnt + 2'd1;
                        grp.tok[cnt] = '{cst_pkg::K_UNKNOWN, sline_reg,
                                         cst_pkg::sat_add_col(scol_reg, len_reg),
                                         cst_pkg::sat_add_off(soff_reg, len_reg),
                                         cst_pkg::LEN_W'(1)};
                        cnt = cnt + 2'd1;
                    end
                    cst_pkg::M_SLASH, cst_pkg::M_PLUS, cst_pkg::M_MINUS, cst_pkg::M_EQ,
                    cst_pkg::M_BANG, cst_pkg::M_LT, cst_pkg::M_GT: begin
                        grp.tok[cnt].line   = sline_reg;
                        grp.tok[cnt].column = scol_reg;
                        grp.tok[cnt].offset = soff_reg;
                        grp.tok[cnt].length = len_reg;
                        unique case (mode_reg)
                            cst_pkg::M_SLASH: grp.tok[cnt].kind = cst_pkg::K_SLASH;
                            cst_pkg::M_PLUS:  grp.tok[cnt].kind = cst_pkg::K_PLUS;
                            cst_pkg::M_MINUS: grp.tok[cnt].kind = cst_pkg::K_MINUS;
                            cst_pkg::M_EQ:    grp.tok[cnt].kind = cst_pkg::K_ASSIGN;
                            cst_pkg::M_BANG:  grp.tok[cnt].kind = cst_pkg::K_NOT;
                            cst_pkg::M_LT:    grp.tok[cnt].kind = cst_pkg::K_LT;
                            default:          grp.tok[cnt].kind = cst_pkg::K_GT;
                        endcase
                        cnt = cnt + 2'd1;
                    end
                    default: begin
                    end
                endcase
                grp.tok[cnt] = '{cst_pkg::K_EOF, line_reg, col_reg, off_reg, '0};
                cnt = cnt + 2'd1;
                mode_next = cst_pkg::M_IDLE;
                fin_next  = 1'b1;
            end else begin
                // Continue the token in progress.
                unique case (mode_reg)
                    cst_pkg::M_IDENT: begin
                        if (cst_pkg::is_alpha(c) || cst_pkg::is_digit(c)) begin
                            if (len_reg < cst_pkg::LEN_W'(cst_pkg::KW_BUF_LEN)) begin
                                pf_we  = 1'b1;
                                pf_idx = len_reg[2:0];
                            end
                            len_next = cst_pkg::sat_inc_len(len_reg);
                        end else begin
                            grp.tok[cnt] = '{idk, sline_reg, scol_reg, soff_reg, len_reg};
                            cnt = cnt + 2'd1;
                            again = 1'b1;
                        end
                    end
                    cst_pkg::M_NUM: begin
                        if (cst_pkg::is_digit(c)) begin
                            len_next = cst_pkg::sat_inc_len(len_reg);
                        end else if (c == "." && !frac_reg) begin
                            mode_next = cst_pkg::M_NUM_DOT;
                        end else if (c == "L" || c == "l") begin
                            len_next = cst_pkg::sat_inc_len(len_reg);
                            grp.tok[cnt] = '{frac_reg ? cst_pkg::K_FLOAT_LIT
                                                      : cst_pkg::K_LONG_LIT,
                                             sline_reg, scol_reg, soff_reg, len_next};
                            cnt = cnt + 2'd1;
                            mode_next = cst_pkg::M_IDLE;
                        end else begin
                            grp.tok[cnt] = '{frac_reg ? cst_pkg::K_FLOAT_LIT
                                                      : cst_pkg::K_INT_LIT,
                                             sline_reg, scol_reg, soff_reg, len_reg};
                            cnt = cnt + 2'd1;
                            again = 1'b1;
                        end
                    end
                    cst_pkg::M_NUM_DOT: begin
                        if (cst_pkg::is_digit(c)) begin
                            frac_next = 1'b1;
                            len_next  = cst_pkg::sat_inc_len(cst_pkg::sat_inc_len(len_reg));
                            mode_next = cst_pkg::M_NUM;
                        end else begin
                            grp.tok[cnt] = '{cst_pkg::K_INT_LIT, sline_reg, scol_reg,
                                             soff_reg, len_reg};
                            cnt = cnt + 2'd1;
                            grp.tok[cnt] = '{cst_pkg::K_UNKNOWN, sline_reg,
                                             cst_pkg::sat_add_col(scol_reg, len_reg),
                                             cst_pkg::sat_add_off(soff_reg, len_reg),
                                             cst_pkg::LEN_W'(1)};
                            cnt = cnt + 2'd1;
                            again = 1'b1;
                        end
                    end
                    cst_pkg::M_STR: begin
                        if (c == 8'h22) begin
                            grp.tok[cnt] = '{cst_pkg::K_STR_LIT, sline_reg, scol_reg,
                                             soff_reg, len_reg};
                            cnt = cnt + 2'd1;
                            mode_next = cst_pkg::M_IDLE;
                        end else begin
                            len_next = cst_pkg::sat_inc_len(len_reg);
                        end
                    end
                    cst_pkg::M_LINE: begin
                        if (c == 8'h0A) begin
                            mode_next = cst_pkg::M_IDLE;
                        end
                    end
                    cst_pkg::M_BLOCK: begin
                        if (c == "*") begin
                            mode_next = cst_pkg::M_BLOCK_STAR;
                        end
                    end
                    cst_pkg::M_BLOCK_STAR: begin
                        if (c == "/") begin
                            mode_next = cst_pkg::M_IDLE;
                        end else if (c != "*") begin
                            mode_next = cst_pkg::M_BLOCK;
                        end
                    end
                    cst_pkg::M_SLASH: begin
                        if (c == "/") begin
                            mode_next = cst_pkg::M_LINE;
                        end else if (c == "*") begin
                            mode_next = cst_pkg::M_BLOCK;
                        end else begin
                            grp.tok[cnt] = '{cst_pkg::K_SLASH, sline_reg, scol_reg,
                                             soff_reg, len_reg};
                            cnt = cnt + 2'd1;
                            again = 1'b1;
                        end
                    end
                    cst_pkg::M_PLUS, cst_pkg::M_MINUS, cst_pkg::M_EQ, cst_pkg::M_BANG,
                    cst_pkg::M_LT, cst_pkg::M_GT: begin
                        // Operators that may take a second character.
                        grp.tok[cnt].line   = sline_reg;
                        grp.tok[cnt].column = scol_reg;
                        grp.tok[cnt].offset = soff_reg;
                        grp.tok[cnt].length = cst_pkg::LEN_W'(2);
                        mode_next = cst_pkg::M_IDLE;
                        len_next  = cst_pkg::LEN_W'(2);
                        unique case (mode_reg)
                            cst_pkg::M_PLUS: begin
                                if (c == "+") begin
                                    grp.tok[cnt].kind = cst_pkg::K_INC;
                                end else if (c == "=") begin
                                    grp.tok[cnt].kind = cst_pkg::K_PLUSEQ;
                                end else begin
                                    grp.tok[cnt].kind = cst_pkg::K_PLUS;
                                    again = 1'b1;
                                end
                            end
                            cst_pkg::M_MINUS: begin
                                if (c == "-") begin
                                    grp.tok[cnt].kind = cst_pkg::K_DEC;
                                end else if (c == "=") begin
                                    grp.tok[cnt].kind = cst_pkg::K_MINUSEQ;
                                end else begin
                                    grp.tok[cnt].kind = cst_pkg::K_MINUS;
                                    again = 1'b1;
                                end
                            end
                            cst_pkg::M_EQ: begin
                                grp.tok[cnt].kind = (c == "=") ? cst_pkg::K_EQ
                                                               : cst_pkg::K_ASSIGN;
                                again = (c != "=");
                            end
                            cst_pkg::M_BANG: begin
                                grp.tok[cnt].kind = (c == "=") ? cst_pkg::K_NE
                                                               : cst_pkg::K_NOT;
                                again = (c != "=");
                            end
                            cst_pkg::M_LT: begin
                                grp.tok[cnt].kind = (c == "=") ? cst_pkg::K_LE
                                                               : cst_pkg::K_LT;
                                again = (c != "=");
                            end
                            default: begin
                                grp.tok[cnt].kind = (c == "=") ? cst_pkg::K_GE
                                                               : cst_pkg::K_GT;
                                again = (c != "=");
                            end
                        endcase
                        // A single-character operator keeps its own length.
                        if (again) begin
                            grp.tok[cnt].length = len_reg;
                            len_next = len_reg;
                        end
                        cnt = cnt + 2'd1;
                    end
                    cst_pkg::M_AMP, cst_pkg::M_BAR: begin
                        if ((mode_reg == cst_pkg::M_AMP && c == "&") ||
                            (mode_reg == cst_pkg::M_BAR && c == "|")) begin
                            grp.tok[cnt] = '{(mode_reg == cst_pkg::M_AMP) ? cst_pkg::K_AND
                                                                         : cst_pkg::K_OR,
                                             sline_reg, scol_reg, soff_reg,
                                             cst_pkg::LEN_W'(2)};
                            cnt = cnt + 2'd1;
                            len_next  = cst_pkg::LEN_W'(2);
                            mode_next = cst_pkg::M_IDLE;
                        end else begin
                            again = 1'b1;
                        end
                    end
                    default: begin
                        again = 1'b1;
                    end
                endcase

                // Byte seen between tokens: start a token or emit a single one.
                if (again) begin
                    mode_next = cst_pkg::M_IDLE;
                    unique case (c)
                        8'h20, 8'h0D, 8'h09, 8'h0A: begin
                        end
                        "(", ")", "{", "}", "[", "]", ";", ",", "%", "*": begin
                            grp.tok[cnt].line   = line_reg;
                            grp.tok[cnt].column = col_reg;
                            grp.tok[cnt].offset = off_reg;
                            grp.tok[cnt].length = cst_pkg::LEN_W'(1);
                            unique case (c)
                                "(":     grp.tok[cnt].kind = cst_pkg::K_LPAREN;
                                ")":     grp.tok[cnt].kind = cst_pkg::K_RPAREN;
                                "{":     grp.tok[cnt].kind = cst_pkg::K_LBRACE;
                                "}":     grp.tok[cnt].kind = cst_pkg::K_RBRACE;
                                "[":     grp.tok[cnt].kind = cst_pkg::K_LBRACKET;
                                "]":     grp.tok[cnt].kind = cst_pkg::K_RBRACKET;
                                ";":     grp.tok[cnt].kind = cst_pkg::K_SEMI;
                                ",":     grp.tok[cnt].kind = cst_pkg::K_COMMA;
                                "%":     grp.tok[cnt].kind = cst_pkg::K_PERCENT;
                                default: grp.tok[cnt].kind = cst_pkg::K_STAR;
                            endcase
                            cnt = cnt + 2'd1;
                        end
                        "+", "-", "/", "=", "!", "<", ">", "&", "|", 8'h22: begin
                            sline_next = line_reg;
                            scol_next  = col_reg;
                            soff_next  = off_reg;
                            len_next   = cst_pkg::LEN_W'(1);
                            unique case (c)
                                "+":     mode_next = cst_pkg::M_PLUS;
                                "-":     mode_next = cst_pkg::M_MINUS;
                                "/":     mode_next = cst_pkg::M_SLASH;
                                "=":     mode_next = cst_pkg::M_EQ;
                                "!":     mode_next = cst_pkg::M_BANG;
                                "<":     mode_next = cst_pkg::M_LT;
                                ">":     mode_next = cst_pkg::M_GT;
                                "&":     mode_next = cst_pkg::M_AMP;
                                "|":     mode_next = cst_pkg::M_BAR;
                                default: begin
                                    // String text starts after the opening quote.
                                    mode_next = cst_pkg::M_STR;
                                    soff_next = cst_pkg::sat_inc_off(off_reg);
                                    len_next  = '0;
                                end
                            endcase
                        end
                        "#": begin
                            mode_next = cst_pkg::M_LINE;
                        end
                        default: begin
                            if (cst_pkg::is_digit(c)) begin
                                mode_next  = cst_pkg::M_NUM;
                                sline_next = line_reg;
                                scol_next  = col_reg;
                                soff_next  = off_reg;
                                len_next   = cst_pkg::LEN_W'(1);
                                frac_next  = 1'b0;
                            end else if (cst_pkg::is_alpha(c)) begin
                                mode_next  = cst_pkg::M_IDENT;
                                sline_next = line_reg;
                                scol_next  = col_reg;
                                soff_next  = off_reg;
                                len_next   = cst_pkg::LEN_W'(1);
                                pf_we      = 1'b1;
                                pf_idx     = '0;
                            end else begin
                                grp.tok[cnt] = '{cst_pkg::K_UNKNOWN, line_reg, col_reg,
                                                 off_reg, cst_pkg::LEN_W'(1)};
                                cnt = cnt + 2'd1;
                            end
                        end
                    endcase
                end

                // Position counters, saturating.
                if (c == 8'h0A) begin
                    line_next = cst_pkg::sat_inc_line(line_reg);
                    col_next  = cst_pkg::COL_W'(1);
                end else begin
                    col_next  = cst_pkg::sat_inc_col(col_reg);
                end
                off_next = cst_pkg::sat_inc_off(off_reg);
            end
        end
        grp.count = cnt;
        grp_push  = (cnt != 2'd0);
    end

endmodule

`default_nettype wire

// File: sv/cst_queue.sv
// Short queue of token groups between the scanner front end and the output
// stage. Depends on cst_pkg for the group type and depth.
`default_nettype none

module cst_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire cst_pkg::group_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output cst_pkg::group_t      head
);

    localparam int PTR_W = $clog2(cst_pkg::QUEUE_DEPTH);

    cst_pkg::group_t      mem [cst_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_reg, rd_reg;
    logic [PTR_W:0]       cnt_reg;

    assign full      = (cnt_reg == (PTR_W + 1)'(cst_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
        end
    end

endmodule

`default_nettype wire

// File: sv/cst_back.sv
// Output stage: takes token groups from the queue and sends them one token
// per beat, marking the last token of each group. Depends on cst_pkg.
`default_nettype none

module cst_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    input  wire cst_pkg::group_t            q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [cst_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast
);

    cst_pkg::group_t grp_reg, grp_next;
    logic [1:0]      idx_reg, idx_next;
    logic            busy_reg, busy_next;
    logic            last;
    cst_pkg::token_t cur;

    assign last = ((idx_reg + 2'd1) == grp_reg.count);
    assign cur  = grp_reg.tok[idx_reg];

    // Field packing, kind in the lowest bits.
    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {6'd0, cur.length, cur.offset, cur.column, cur.line, cur.kind};

    // Load a new group when idle or when the last token leaves.
    always_comb begin
        q_pop     = q_valid && (!busy_reg || (m_tready && last));
        grp_next  = grp_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (q_pop) begin
            grp_next  = q_head;
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg && m_tready) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

endmodule

`default_nettype wire

// File: sv/c_subset_token_scanner.sv
// C subset token scanner: one source byte per beat in, tokens out.
// A completed token is written to the group queue, then registered in the output stage.
// Throughput: one byte per cycle while each byte yields at most one token and the
// output is not stalled; a byte completing two or three tokens sends one beat each.
// Reset (aresetn low, synchronous): position line 1 column 1, offset 0, queue empty.
`default_nettype none

module c_subset_token_scanner (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // ch
    input  wire logic [0:0]   s_tuser,   // op
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // token_kind, token_line, token_column,
                                         // token_offset, token_length, zero pad
    output logic              m_tlast    // last_of_run
);

    cst_pkg::group_t grp, head;
    logic            grp_push, q_full, q_valid, q_pop, in_fire;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    // Scanner front end.
    cst_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_op    (s_tuser[0]),
        .in_ch    (s_tdata),
        .grp      (grp),
        .grp_push (grp_push)
    );

    // Token group queue.
    cst_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (grp_push),
        .push_data (grp),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head)
    );

    // Output stage.
    cst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for the C subset token scanner: drives source bytes and end items
// as beats, predicts the emitted tokens and compares them with the output.
// Depends on cst_pkg and the c_subset_token_scanner top level.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
    } src_item_t;

    typedef struct packed {
        logic [cst_pkg::KIND_W-1:0] kind;
        logic [cst_pkg::LINE_W-1:0] line;
        logic [cst_pkg::COL_W-1:0]  column;
        logic [cst_pkg::OFF_W-1:0]  offset;
        logic [cst_pkg::LEN_W-1:0]  length;
        logic                       last;
    } tok_exp_t;

    localparam logic [cst_pkg::LEN_W-1:0] LEN_ZERO = '0;
    localparam logic [cst_pkg::LEN_W-1:0] LEN_ONE  = cst_pkg::LEN_W'(1);
    localparam logic [cst_pkg::LEN_W-1:0] LEN_TWO  = cst_pkg::LEN_W'(2);

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tlast;

    c_subset_token_scanner dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    src_item_t pending_src[$];
    tok_exp_t  expected_tokens[$];
    int        error_count = 0;
    bit        hold_sender = 1'b0;
    bit        stall_long = 1'b0;

    // Scanner state mirror.
    cst_pkg::mode_t             sc_mode;
    logic [cst_pkg::LINE_W-1:0] sc_line, sc_sline;
    logic [cst_pkg::COL_W-1:0]  sc_col, sc_scol;
    logic [cst_pkg::OFF_W-1:0]  sc_off, sc_soff;
    logic [cst_pkg::LEN_W-1:0]  sc_len;
    logic                       sc_frac;
    logic [7:0]                 sc_prefix[cst_pkg::KW_BUF_LEN];
    logic                       sc_done;
    tok_exp_t                   step_toks[$];

    // Append one source beat to the pending list.
    function automatic void add_src(logic op, logic [7:0] ch);
        src_item_t it;
        it = '{op, ch};
        pending_src = {pending_src, it};
    endfunction

    function automatic logic dig(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic alp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [cst_pkg::OFF_W-1:0] off_plus(logic [cst_pkg::OFF_W-1:0] a,
                                                         logic [cst_pkg::LEN_W-1:0] b);
        logic [cst_pkg::OFF_W:0] s;
        s = {1'b0, a} + (cst_pkg::OFF_W + 1)'(b);
        return s[cst_pkg::OFF_W] ? '1 : s[cst_pkg::OFF_W-1:0];
    endfunction

    function automatic logic [cst_pkg::COL_W-1:0] col_plus(logic [cst_pkg::COL_W-1:0] a,
                                                         logic [cst_pkg::LEN_W-1:0] b);
        logic [cst_pkg::COL_W:0] s;
        s = {1'b0, a} + (cst_pkg::COL_W + 1)'(b);
        return s[cst_pkg::COL_W] ? '1 : s[cst_pkg::COL_W-1:0];
    endfunction

    function automatic void push_tok(logic [cst_pkg::KIND_W-1:0] k,
                                     logic [cst_pkg::LINE_W-1:0] l,
                                     logic [cst_pkg::COL_W-1:0] c,
                                     logic [cst_pkg::OFF_W-1:0] o,
                                     logic [cst_pkg::LEN_W-1:0] n);
        tok_exp_t t;
        t = '{k, l, c, o, n, 1'b0};
        if (step_toks.size() < cst_pkg::MAX_TOKENS) step_toks = {step_toks, t};
    endfunction

    function automatic void push_started(logic [cst_pkg::KIND_W-1:0] k);
        push_tok(k, sc_sline, sc_scol, sc_soff, sc_len);
    endfunction

    task automatic begin_lexeme(cst_pkg::mode_t m);
        sc_mode = m;
        sc_sline = sc_line;
        sc_scol = sc_col;
        sc_soff = sc_off;
        sc_len = LEN_ONE;
    endtask

    // Keyword lookup over the kept identifier prefix.
    task automatic push_word();
        string words[11];
        logic [cst_pkg::KIND_W-1:0] k;
        bit hit;
        words = '{"int", "float", "long", "unsigned", "if", "else", "while", "for",
                  "return", "printf", "include"};
        k = cst_pkg::K_IDENT;
        if (sc_len <= cst_pkg::KW_BUF_LEN) begin
            for (int i = 0; i < 11; i++) begin
                if (k == cst_pkg::K_IDENT && words[i].len() == sc_len) begin
                    hit = 1'b1;
                    for (int j = 0; j < words[i].len(); j++)
                        if (sc_prefix[j] != words[i][j]) hit = 1'b0;
                    if (hit) k = cst_pkg::K_KW0 + cst_pkg::KIND_W'(i);
                end
            end
        end
        push_started(k);
    endtask

    task automatic push_int_dot();
        push_started(cst_pkg::K_INT_LIT);
        push_tok(cst_pkg::K_UNKNOWN, sc_sline, col_plus(sc_scol, sc_len),
                 off_plus(sc_soff, sc_len), LEN_ONE);
    endtask

    task automatic len_up();
        if (sc_len != '1) sc_len++;
    endtask

    // A byte seen between tokens.
    task automatic fresh_byte(logic [7:0] c);
        sc_mode = cst_pkg::M_IDLE;
        case (c)
            " ", 8'h0d, 8'h09, 8'h0a: ;
            "(": push_tok(cst_pkg::K_LPAREN, sc_line, sc_col, sc_off, LEN_ONE);
            ")": push_tok(cst_pkg::K_RPAREN, sc_line, sc_col, sc_off, LEN_ONE);
            "{": push_tok(cst_pkg::K_LBRACE, sc_line, sc_col, sc_off, LEN_ONE);
            "}": push_tok(cst_pkg::K_RBRACE, sc_line, sc_col, sc_off, LEN_ONE);
            "[": push_tok(cst_pkg::K_LBRACKET, sc_line, sc_col, sc_off, LEN_ONE);
            "]": push_tok(cst_pkg::K_RBRACKET, sc_line, sc_col, sc_off, LEN_ONE);
            ";": push_tok(cst_pkg::K_SEMI, sc_line, sc_col, sc_off, LEN_ONE);
            ",": push_tok(cst_pkg::K_COMMA, sc_line, sc_col, sc_off, LEN_ONE);
            "%": push_tok(cst_pkg::K_PERCENT, sc_line, sc_col, sc_off, LEN_ONE);
            "*": push_tok(cst_pkg::K_STAR, sc_line, sc_col, sc_off, LEN_ONE);
            "+": begin_lexeme(cst_pkg::M_PLUS);
            "-": begin_lexeme(cst_pkg::M_MINUS);
            "/": begin_lexeme(cst_pkg::M_SLASH);
            "=": begin_lexeme(cst_pkg::M_EQ);
            "!": begin_lexeme(cst_pkg::M_BANG);
            "<": begin_lexeme(cst_pkg::M_LT);
            ">": begin_lexeme(cst_pkg::M_GT);
            "&": begin_lexeme(cst_pkg::M_AMP);
            "|": begin_lexeme(cst_pkg::M_BAR);
            "#": sc_mode = cst_pkg::M_LINE;
            8'h22: begin
                begin_lexeme(cst_pkg::M_STR);
                sc_soff = off_plus(sc_off, LEN_ONE);
                sc_len = LEN_ZERO;
            end
            default: begin
                if (dig(c)) begin
                    begin_lexeme(cst_pkg::M_NUM);
                    sc_frac = 1'b0;
                end else if (alp(c)) begin
                    begin_lexeme(cst_pkg::M_IDENT);
                    sc_prefix[0] = c;
                end else begin
                    push_tok(cst_pkg::K_UNKNOWN, sc_line, sc_col, sc_off, LEN_ONE);
                end
            end
        endcase
    endtask

    // Two-character operator check; returns 1 when the byte must be rescanned.
    function automatic bit try_pair(logic [7:0] c, logic [7:0] second,
                                    logic [cst_pkg::KIND_W-1:0] k2,
                                    logic [cst_pkg::KIND_W-1:0] k1);
        if (c == second) begin
            sc_len = LEN_TWO;
            push_started(k2);
            sc_mode = cst_pkg::M_IDLE;
            return 1'b0;
        end
        push_started(k1);
        return 1'b1;
    endfunction

    task automatic scan_source_byte(logic [7:0] c);
        bit again;
        again = 1'b0;
        case (sc_mode)
            cst_pkg::M_IDENT: begin
                if (alp(c) || dig(c)) begin
                    if (sc_len < cst_pkg::KW_BUF_LEN) sc_prefix[sc_len[2:0]] = c;
                    len_up();
                end else begin
                    push_word();
                    again = 1'b1;
                end
            end
            cst_pkg::M_NUM: begin
                if (dig(c)) len_up();
                else if (c == "." && !sc_frac) sc_mode = cst_pkg::M_NUM_DOT;
                else if (c == "L" || c == "l") begin
                    len_up();
                    push_started(sc_frac ? cst_pkg::K_FLOAT_LIT : cst_pkg::K_LONG_LIT);
                    sc_mode = cst_pkg::M_IDLE;
                end else begin
                    push_started(sc_frac ? cst_pkg::K_FLOAT_LIT : cst_pkg::K_INT_LIT);
                    again = 1'b1;
                end
            end
            cst_pkg::M_NUM_DOT: begin
                if (dig(c)) begin
                    sc_frac = 1'b1;
                    len_up();
                    len_up();
                    sc_mode = cst_pkg::M_NUM;
                end else begin
                    push_int_dot();
                    again = 1'b1;
                end
            end
            cst_pkg::M_STR: begin
                if (c == 8'h22) begin
                    push_started(cst_pkg::K_STR_LIT);
                    sc_mode = cst_pkg::M_IDLE;
                end else len_up();
            end
            cst_pkg::M_LINE: if (c == 8'h0a) sc_mode = cst_pkg::M_IDLE;
            cst_pkg::M_BLOCK: if (c == "*") sc_mode = cst_pkg::M_BLOCK_STAR;
            cst_pkg::M_BLOCK_STAR: begin
                if (c == "/") sc_mode = cst_pkg::M_IDLE;
                else if (c != "*") sc_mode = cst_pkg::M_BLOCK;
            end
            cst_pkg::M_SLASH: begin
                if (c == "/") sc_mode = cst_pkg::M_LINE;
                else if (c == "*") sc_mode = cst_pkg::M_BLOCK;
                else begin
                    push_started(cst_pkg::K_SLASH);
                    again = 1'b1;
                end
            end
            cst_pkg::M_PLUS: again = (c == "+")
                ? try_pair(c, "+", cst_pkg::K_INC, cst_pkg::K_PLUS)
                : try_pair(c, "=", cst_pkg::K_PLUSEQ, cst_pkg::K_PLUS);
            cst_pkg::M_MINUS: again = (c == "-")
                ? try_pair(c, "-", cst_pkg::K_DEC, cst_pkg::K_MINUS)
                : try_pair(c, "=", cst_pkg::K_MINUSEQ, cst_pkg::K_MINUS);
            cst_pkg::M_EQ: again = try_pair(c, "=", cst_pkg::K_EQ, cst_pkg::K_ASSIGN);
            cst_pkg::M_BANG: again = try_pair(c, "=", cst_pkg::K_NE, cst_pkg::K_NOT);
            cst_pkg::M_LT: again = try_pair(c, "=", cst_pkg::K_LE, cst_pkg::K_LT);
            cst_pkg::M_GT: again = try_pair(c, "=", cst_pkg::K_GE, cst_pkg::K_GT);
            cst_pkg::M_AMP, cst_pkg::M_BAR: begin
                if (c == ((sc_mode == cst_pkg::M_AMP) ? "&" : "|")) begin
                    sc_len = LEN_TWO;
                    push_started(sc_mode == cst_pkg::M_AMP ? cst_pkg::K_AND : cst_pkg::K_OR);
                    sc_mode = cst_pkg::M_IDLE;
                end else again = 1'b1;
            end
            default: again = 1'b1;
        endcase
        if (again) fresh_byte(c);
        if (c == 8'h0a) begin
            if (sc_line != '1) sc_line++;
            sc_col = cst_pkg::COL_W'(1);
        end else if (sc_col != '1) sc_col++;
        if (sc_off != '1) sc_off++;
    endtask

    task automatic finish_input();
        case (sc_mode)
            cst_pkg::M_IDENT: push_word();
            cst_pkg::M_NUM: push_started(sc_frac ? cst_pkg::K_FLOAT_LIT : cst_pkg::K_INT_LIT);
            cst_pkg::M_NUM_DOT: push_int_dot();
            cst_pkg::M_SLASH: push_started(cst_pkg::K_SLASH);
            cst_pkg::M_PLUS: push_started(cst_pkg::K_PLUS);
            cst_pkg::M_MINUS: push_started(cst_pkg::K_MINUS);
            cst_pkg::M_EQ: push_started(cst_pkg::K_ASSIGN);
            cst_pkg::M_BANG: push_started(cst_pkg::K_NOT);
            cst_pkg::M_LT: push_started(cst_pkg::K_LT);
            cst_pkg::M_GT: push_started(cst_pkg::K_GT);
            default: ;
        endcase
        sc_mode = cst_pkg::M_IDLE;
        push_tok(cst_pkg::K_EOF, sc_line, sc_col, sc_off, LEN_ZERO);
    endtask

    // Predict the tokens of one accepted beat.
    task automatic predict_tokens(src_item_t it);
        step_toks.delete();
        if (!sc_done) begin
            if (it.op) begin
                finish_input();
                sc_done = 1'b1;
            end else scan_source_byte(it.ch);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) expected_tokens = {expected_tokens, step_toks[i]};
    endtask

    task automatic reset_scanner_model();
        sc_mode = cst_pkg::M_IDLE;
        sc_line = cst_pkg::LINE_W'(1);
        sc_col = cst_pkg::COL_W'(1);
        sc_off = '0;
        sc_sline = '0;
        sc_scol = '0;
        sc_soff = '0;
        sc_len = LEN_ZERO;
        sc_frac = 1'b0;
        foreach (sc_prefix[i]) sc_prefix[i] = 8'h00;
        sc_done = 1'b0;
    endtask

    // Driver: bursts of beats with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_tokens(src_item_t'{s_tuser[0], s_tdata});
                void'(pending_src.pop_front());
            end
            if ((s_tvalid && !s_tready) || (s_tvalid && s_tready && pending_src.size() > 0
                    && burst_left > 0 && !hold_sender)) begin
                if (s_tready) begin
                    s_tdata <= pending_src[0].ch;
                    s_tuser <= pending_src[0].op;
                    burst_left <= burst_left - 1;
                end
            end else if (gap_left > 0 || hold_sender || pending_src.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                burst_left <= $urandom_range(1, 20);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_src[0].ch;
                s_tuser <= pending_src[0].op;
                burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: receiver stall pattern and token comparison.
    logic [15:0] stall_pattern = 16'h0;
    int          phase = 0;
    always @(posedge aclk) begin
        tok_exp_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token beat with nothing expected: %h", m_tdata);
                    error_count++;
                end else begin
                    e = expected_tokens.pop_front();
                    if (m_tdata[5:0] !== e.kind) begin
                        $error("token_kind expected %0d actual %0d", e.kind, m_tdata[5:0]);
                        error_count++;
                    end
                    if (m_tdata[25:6] !== e.line) begin
                        $error("token_line expected %0d actual %0d", e.line, m_tdata[25:6]);
                        error_count++;
                    end
                    if (m_tdata[41:26] !== e.column) begin
                        $error("token_column expected %0d actual %0d", e.column,
                               m_tdata[41:26]);
                        error_count++;
                    end
                    if (m_tdata[73:42] !== e.offset) begin
                        $error("token_offset expected %0d actual %0d", e.offset,
                               m_tdata[73:42]);
                        error_count++;
                    end
                    if (m_tdata[89:74] !== e.length) begin
                        $error("token_length expected %0d actual %0d", e.length,
                               m_tdata[89:74]);
                        error_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_of_run expected %0d actual %0d", e.last, m_tlast);
                        error_count++;
                    end
                end
            end
            if (phase == 0) begin
                stall_pattern <= $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom);
                phase <= 16;
            end else phase <= phase - 1;
            m_tready <= !stall_long && !stall_pattern[phase % 16];
        end
    end

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_src(1'b0, s[i]);
    endtask

    task automatic wait_drained();
        while (pending_src.size() > 0 || expected_tokens.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Random source fragment, mostly well-formed C-like pieces.
    task automatic add_random_piece();
        string pieces[22];
        int n;
        pieces = '{"int ", "float x", "unsigned", "while(", "return 0;", "printf",
                   "include", "12.5L", "3.", "77l", "1.2.3", "\"ab c\"", "// cm\n",
                   "/* a**b */", "#inc\n", "a+=b", "c--", "x==y", "p!=q", "a&&b||c",
                   "<=>=", "abcdefghijk "};
        case ($urandom_range(0, 9))
            0, 1: add_src(1'b0, 8'($urandom_range(0, 255)));
            2: add_src(1'b0, 8'h0a);
            default: begin
                n = $urandom_range(0, 21);
                add_text(pieces[n]);
                if ($urandom_range(0, 1)) add_src(1'b0, " ");
            end
        endcase
    endtask

    initial begin
        reset_scanner_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // Directed: keywords, operators, numbers with a trailing dot, lone & and |,
        // comments, strings, and every bit of the byte field.
        add_text("if else for ++ -- & | 12.x ");
        add_text("/*x*/\"s\"\n");
        add_src(1'b0, 8'hff);
        add_src(1'b0, 8'h00);
        // Hold the receiver off long so the block fills up and stalls input.
        stall_long = 1'b1;
        repeat (200) @(posedge aclk);
        stall_long = 1'b0;
        wait_drained();
        // Random source: the sender pauses once until every token has come.
        for (int i = 0; i < 20; i++) begin
            add_random_piece();
            if (i == 10) begin
                hold_sender = 1'b0;
                wait_drained();
            end
        end
        add_text("\"open");
        add_src(1'b1, 8'($urandom_range(0, 255)));
        // Items after end are ignored.
        add_text("a+b");
        add_src(1'b1, 8'h00);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #12ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire

// File: filelist.f
sv/cst_pkg.sv
sv/cst_front.sv
sv/cst_queue.sv
sv/cst_back.sv
sv/c_subset_token_scanner.sv
tb/sv/testbench.sv
